>>> rtl/pmd_pkg.sv
// Shared types, widths and constants for the PID motor drive.
`timescale 1ns / 1ps

package pmd_pkg;

  localparam int ANGLE_W = 16;
  localparam int STEP_W  = 16;
  localparam int GAIN_W  = 16;
  localparam int ERR_W   = 18;
  localparam int DE_W    = 19;
  localparam int PROD_W  = 36;
  localparam int INTEG_W = 48;
  localparam int NUM_W   = 49;
  localparam int ACC_W   = 52;
  localparam int CV_W    = 32;
  localparam int SPEED_W = 7;
  localparam int CNT_W   = 6;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic signed [ERR_W-1:0] ANGLE_OFFSET = 18'sd46080;
  localparam logic [SPEED_W-1:0]      SPEED_CAP    = 7'd100;

  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_KP     = 2'd1;
  localparam logic [1:0] REG_KI     = 2'd2;
  localparam logic [1:0] REG_KD     = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL_ES,
    ST_INTEG,
    ST_DIV_LOAD,
    ST_ACC_P,
    ST_ACC_LO,
    ST_ACC_MID,
    ST_ACC_HI,
    ST_DIV_WAIT,
    ST_ADD_D,
    ST_FIN,
    ST_ZERO
  } state_t;

  typedef enum logic [2:0] {
    MUL_ERR_STEP,
    MUL_KD_DE,
    MUL_KP_ERR,
    MUL_KI_LO,
    MUL_KI_MID,
    MUL_KI_HI
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_P,
    ACC_ADD_LO,
    ACC_ADD_MID,
    ACC_ADD_HI,
    ACC_ADD_D
  } acc_op_t;

  typedef struct packed {
    logic     load_in;
    logic     load_err;
    mul_sel_t mul_sel;
    logic     integ_upd;
    logic     div_start;
    acc_op_t  acc_op;
    logic     out_load;
    logic     out_zero;
  } dp_cmd_t;

  typedef struct packed {
    logic enable;
    logic div_busy;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/pmd_div.sv
// Serial restoring divider, one quotient bit per cycle, unsigned operands.
`timescale 1ns / 1ps

module pmd_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pmd_pkg::NUM_W-1:0]  num,
  input  logic [pmd_pkg::STEP_W-1:0] den,
  output logic                       busy,
  output logic [pmd_pkg::NUM_W-1:0]  quot
);
  import pmd_pkg::*;

  logic [CNT_W-1:0]  count;
  logic [STEP_W-1:0] rem;
  logic [STEP_W-1:0] divisor;
  logic [NUM_W-1:0]  shreg;
  logic [STEP_W:0]   trial;
  logic              fits;

  assign trial = {rem, shreg[NUM_W-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign busy  = count != '0;
  assign quot  = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CNT_W'(NUM_W);
    end else if (busy) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= '0;
      divisor <= den;
      shreg   <= num;
    end else if (busy) begin
      if (fits) begin
        rem <= STEP_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[STEP_W-1:0];
      end
      shreg <= {shreg[NUM_W-2:0], fits};
    end
  end

endmodule

>>> rtl/pmd_dp.sv
// Datapath: input and state registers, shared multiplier, accumulator, output word register.
`timescale 1ns / 1ps

module pmd_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  pmd_pkg::dp_cmd_t            cmd,
  output pmd_pkg::dp_status_t         status,
  input  logic                        loop_enable,
  input  logic [pmd_pkg::GAIN_W-1:0]  gain_proportional,
  input  logic [pmd_pkg::GAIN_W-1:0]  gain_integral,
  input  logic [pmd_pkg::GAIN_W-1:0]  gain_derivative,
  input  logic [pmd_pkg::ANGLE_W-1:0] measured_angle,
  input  logic [pmd_pkg::STEP_W-1:0]  time_step,
  input  logic [pmd_pkg::ANGLE_W-1:0] target_angle,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pmd_pkg::CV_W-1:0]    control_value,
  output logic [pmd_pkg::SPEED_W-1:0] motor_speed,
  output logic                        motor_reverse,
  output logic                        zero_step_flag
);
  import pmd_pkg::*;

  logic [ANGLE_W-1:0] meas;
  logic [STEP_W-1:0]  step;
  logic [ANGLE_W-1:0] target;

  logic signed [ERR_W-1:0]   err;
  logic signed [ERR_W-1:0]   err_next;
  logic signed [ERR_W-1:0]   previous_error;
  logic signed [INTEG_W-1:0] integral_sum;
  logic signed [DE_W-1:0]    de;
  logic signed [ERR_W-1:0]   meas_x;

  logic signed [DE_W-1:0]   mul_a;
  logic [GAIN_W-1:0]        mul_b;
  logic signed [PROD_W-1:0] prod;

  logic signed [INTEG_W:0]   integ_sum;
  logic signed [INTEG_W-1:0] integ_next;

  logic [PROD_W-1:0]  prod_mag;
  logic               div_go;
  logic               div_neg;
  logic               div_busy;
  logic [NUM_W-1:0]   quot;
  logic               zstep;
  logic [ACC_W-1:0]   d_ext;
  logic signed [ACC_W-1:0] d_val;
  logic signed [ACC_W-1:0] acc;

  logic [CV_W-1:0]    cv;
  logic [CV_W:0]      mag;
  logic [CV_W-16:0]   mag_int;
  logic [SPEED_W-1:0] speed;

  assign zstep = step == '0;

  // error term
  assign meas_x = ERR_W'($signed(meas));
  always_comb begin
    if (!meas[ANGLE_W-1]) begin
      err_next = ERR_W'($signed(target)) - meas_x;
    end else begin
      err_next = -ANGLE_OFFSET - meas_x;
    end
  end

  assign de = DE_W'(err) - DE_W'(previous_error);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      meas   <= measured_angle;
      step   <= time_step;
      target <= target_angle;
    end
    if (cmd.load_err) begin
      err <= err_next;
    end
  end

  // shared multiplier, signed 19 x unsigned 16
  always_comb begin
    case (cmd.mul_sel)
      MUL_ERR_STEP: begin
        mul_a = DE_W'(err);
        mul_b = step;
      end
      MUL_KD_DE: begin
        mul_a = de;
        mul_b = gain_derivative;
      end
      MUL_KP_ERR: begin
        mul_a = DE_W'(err);
        mul_b = gain_proportional;
      end
      MUL_KI_LO: begin
        mul_a = $signed({3'b000, integral_sum[15:0]});
        mul_b = gain_integral;
      end
      MUL_KI_MID: begin
        mul_a = $signed({3'b000, integral_sum[31:16]});
        mul_b = gain_integral;
      end
      MUL_KI_HI: begin
        mul_a = DE_W'($signed(integral_sum[INTEG_W-1:32]));
        mul_b = gain_integral;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * $signed({1'b0, mul_b});
  end

  // integral with saturation
  assign integ_sum = (INTEG_W+1)'(integral_sum) + (INTEG_W+1)'(prod);
  always_comb begin
    if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
      integ_next = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                      : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integ_next = integ_sum[INTEG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= '0;
      integral_sum   <= '0;
    end else if (cmd.integ_upd) begin
      previous_error <= err;
      integral_sum   <= integ_next;
    end
  end

  // derivative: |kd*de| * 2^16 / step
  assign prod_mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
  assign div_go   = cmd.div_start && !zstep;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_neg <= prod[PROD_W-1];
    end
  end

  pmd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   ({prod_mag[NUM_W-17:0], 16'h0000}),
    .den   (step),
    .busy  (div_busy),
    .quot  (quot)
  );

  assign d_ext = ACC_W'(quot);
  always_comb begin
    if (zstep) begin
      d_val = '0;
    end else if (div_neg) begin
      d_val = -$signed(d_ext);
    end else begin
      d_val = $signed(d_ext);
    end
  end

  // accumulator: P, then I in three partial products, then D
  always_ff @(posedge clk) begin
    case (cmd.acc_op)
      ACC_LOAD_P:  acc <= ACC_W'(prod);
      ACC_ADD_LO:  acc <= acc + $signed({{(ACC_W-16){1'b0}}, prod[31:16]});
      ACC_ADD_MID: acc <= acc + ACC_W'(prod);
      ACC_ADD_HI:  acc <= acc + $signed({prod, 16'h0000});
      ACC_ADD_D:   acc <= acc + d_val;
      default:     acc <= acc;
    endcase
  end

  // saturate and derive motor command
  always_comb begin
    if (acc[ACC_W-1:CV_W-1] != {(ACC_W-CV_W+1){acc[ACC_W-1]}}) begin
      cv = acc[ACC_W-1] ? {1'b1, {(CV_W-1){1'b0}}} : {1'b0, {(CV_W-1){1'b1}}};
    end else begin
      cv = acc[CV_W-1:0];
    end
    mag     = cv[CV_W-1] ? (CV_W+1)'(-$signed({1'b1, cv})) : {1'b0, cv};
    mag_int = mag[CV_W:16];
    speed   = (mag_int > (CV_W-15)'(SPEED_CAP)) ? SPEED_CAP : mag_int[SPEED_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_zero) begin
        control_value  <= '0;
        motor_speed    <= '0;
        motor_reverse  <= 1'b0;
        zero_step_flag <= 1'b0;
      end else begin
        control_value  <= cv;
        motor_speed    <= speed;
        motor_reverse  <= cv[CV_W-1];
        zero_step_flag <= zstep;
      end
    end
  end

  assign status.enable   = loop_enable;
  assign status.div_busy = div_busy;
  assign status.out_free = !out_valid || out_ready;

endmodule

>>> rtl/pmd_ctrl.sv
// Controller state machine sequencing the datapath for one word at a time.
`timescale 1ns / 1ps

module pmd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pmd_pkg::dp_status_t status,
  output pmd_pkg::dp_cmd_t    cmd
);
  import pmd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.mul_sel   = MUL_ERR_STEP;
    cmd.acc_op    = ACC_HOLD;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_next = ST_ERR;
        end
      end
      ST_ERR: begin
        cmd.load_err = 1'b1;
        state_next   = status.enable ? ST_MUL_ES : ST_ZERO;
      end
      ST_MUL_ES: begin
        cmd.mul_sel = MUL_ERR_STEP;
        state_next  = ST_INTEG;
      end
      ST_INTEG: begin
        cmd.integ_upd = 1'b1;
        cmd.mul_sel   = MUL_KD_DE;
        state_next    = ST_DIV_LOAD;
      end
      ST_DIV_LOAD: begin
        cmd.div_start = 1'b1;
        cmd.mul_sel   = MUL_KP_ERR;
        state_next    = ST_ACC_P;
      end
      ST_ACC_P: begin
        cmd.acc_op  = ACC_LOAD_P;
        cmd.mul_sel = MUL_KI_LO;
        state_next  = ST_ACC_LO;
      end
      ST_ACC_LO: begin
        cmd.acc_op  = ACC_ADD_LO;
        cmd.mul_sel = MUL_KI_MID;
        state_next  = ST_ACC_MID;
      end
      ST_ACC_MID: begin
        cmd.acc_op  = ACC_ADD_MID;
        cmd.mul_sel = MUL_KI_HI;
        state_next  = ST_ACC_HI;
      end
      ST_ACC_HI: begin
        cmd.acc_op = ACC_ADD_HI;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!status.div_busy) begin
          state_next = ST_ADD_D;
        end
      end
      ST_ADD_D: begin
        cmd.acc_op = ACC_ADD_D;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_ZERO: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_zero = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/pid_motor_drive.sv
// Top level: register port, controller and datapath of the PID motor drive.
`timescale 1ns / 1ps

// PID controller for angle samples in Q8.8 with a Q0.16 time step, giving a
// saturated Q16.16 control word plus a motor speed (0..100) and direction.
// One input word is taken at a time. With the loop enabled and a nonzero
// step the result waits on the serial divider for the derivative term
// (49 quotient bits, one per cycle); with a zero step the divider is not
// started, and with the loop disabled the result is an all-zero word. The next
// word is accepted in the cycle after the result is loaded, even while that
// result still waits on m_tready. Registers: 0x0 loop_enable, 0x4 kp,
// 0x8 ki, 0xC kd; gains are unsigned Q8.8. Change them only while idle.

module pid_motor_drive (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // measured_angle[15:0], time_step[31:16], target_angle[47:32]
  input  logic [47:0]                s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // control_value[31:0], motor_speed[38:32], motor_reverse[39]
  output logic [39:0]                m_tdata,
  // zero_step_flag[0]
  output logic                       m_tuser,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pmd_pkg::ADDR_W-1:0] paddr,
  input  logic [pmd_pkg::DATA_W-1:0] pwdata,
  output logic [pmd_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import pmd_pkg::*;

  logic              loop_enable;
  logic [GAIN_W-1:0] gain_proportional;
  logic [GAIN_W-1:0] gain_integral;
  logic [GAIN_W-1:0] gain_derivative;
  logic              wr_en;
  logic [1:0]        reg_idx;

  dp_cmd_t    cmd;
  dp_status_t status;

  logic [CV_W-1:0]    control_value;
  logic [SPEED_W-1:0] motor_speed;
  logic               motor_reverse;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_enable       <= 1'b0;
      gain_proportional <= '0;
      gain_integral     <= '0;
      gain_derivative   <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ENABLE: loop_enable       <= pwdata[0];
        REG_KP:     gain_proportional <= pwdata[GAIN_W-1:0];
        REG_KI:     gain_integral     <= pwdata[GAIN_W-1:0];
        REG_KD:     gain_derivative   <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ENABLE: prdata = DATA_W'(loop_enable);
      REG_KP:     prdata = DATA_W'(gain_proportional);
      REG_KI:     prdata = DATA_W'(gain_integral);
      REG_KD:     prdata = DATA_W'(gain_derivative);
      default:    prdata = '0;
    endcase
  end

  pmd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  pmd_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .loop_enable       (loop_enable),
    .gain_proportional (gain_proportional),
    .gain_integral     (gain_integral),
    .gain_derivative   (gain_derivative),
    .measured_angle    (s_tdata[15:0]),
    .time_step         (s_tdata[31:16]),
    .target_angle      (s_tdata[47:32]),
    .out_valid         (m_tvalid),
    .out_ready         (m_tready),
    .control_value     (control_value),
    .motor_speed       (motor_speed),
    .motor_reverse     (motor_reverse),
    .zero_step_flag    (m_tuser)
  );

  assign m_tdata = {motor_reverse, motor_speed, control_value};

endmodule

>>> rtl/pmd_checker.sv
// Port-level assertions for the PID motor drive, bound to the top level.
`timescale 1ns / 1ps

module pmd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a word is in work");

  a_speed_cap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[38:32] <= 7'd100)
    else $error("motor speed above cap");

  a_reverse_sign: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[39] == m_tdata[31])
    else $error("direction does not match control sign");

  a_speed_small: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[31] && m_tdata[30:16] <= 15'd100
      |-> m_tdata[38:32] == m_tdata[22:16])
    else $error("speed does not match control magnitude");

endmodule

bind pid_motor_drive pmd_checker u_pmd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> bench/pid_motor_drive_check.sv
// Checker for the PID motor drive: predicts each result word and compares it with the output.
`timescale 1ns / 1ps

module pid_motor_drive_check (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  // measured_angle[15:0], time_step[31:16], target_angle[47:32]
  input  logic [47:0]                s_tdata,
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  // control_value[31:0], motor_speed[38:32], motor_reverse[39]
  input  logic [39:0]                m_tdata,
  // zero_step_flag[0]
  input  logic                       m_tuser,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pmd_pkg::ADDR_W-1:0] paddr,
  input  logic [pmd_pkg::DATA_W-1:0] pwdata,
  input  logic                       pready,
  output int                         fail_count,
  output int                         pending
);

  typedef struct packed {
    logic [31:0] control;
    logic [6:0]  speed;
    logic        reverse;
    logic        zero_step;
  } drive_cmd_t;

  localparam longint INTEG_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint INTEG_LO = -INTEG_HI - 1;
  localparam longint CV_HI    = 64'sh0000_0000_7FFF_FFFF;
  localparam longint CV_LO    = -CV_HI - 1;

  logic                               loop_on;
  logic [pmd_pkg::GAIN_W-1:0]         kp;
  logic [pmd_pkg::GAIN_W-1:0]         ki;
  logic [pmd_pkg::GAIN_W-1:0]         kd;
  logic signed [pmd_pkg::ERR_W-1:0]   last_err;
  logic signed [pmd_pkg::INTEG_W-1:0] integ;
  drive_cmd_t                         cmd_q[$];

  task automatic predict_cmd(input logic [47:0] word);
    longint     meas;
    longint     step;
    longint     target;
    longint     err;
    longint     acc;
    longint     p;
    longint     i;
    longint     d;
    longint     sum;
    longint     mag;
    drive_cmd_t c;
    meas   = longint'($signed(word[15:0]));
    step   = longint'(word[31:16]);
    target = longint'($signed(word[47:32]));
    c = '0;
    if (loop_on) begin
      if (meas >= 0) begin
        err = target - meas;
      end else begin
        err = -(longint'(pmd_pkg::ANGLE_OFFSET) + meas);
      end
      acc = longint'(integ) + err * step;
      if (acc > INTEG_HI) begin
        acc = INTEG_HI;
      end else if (acc < INTEG_LO) begin
        acc = INTEG_LO;
      end
      integ = acc[pmd_pkg::INTEG_W-1:0];
      p = longint'(kp) * err;
      i = (longint'(ki) * acc) >>> 16;
      if (step == 0) begin
        d = 0;
        c.zero_step = 1'b1;
      end else begin
        d = (longint'(kd) * (err - longint'(last_err)) * 65536) / step;
      end
      last_err = err[pmd_pkg::ERR_W-1:0];
      sum = p + i + d;
      if (sum > CV_HI) begin
        sum = CV_HI;
      end else if (sum < CV_LO) begin
        sum = CV_LO;
      end
      c.control = sum[31:0];
      c.reverse = (sum < 0);
      mag = ((sum < 0) ? -sum : sum) >>> 16;
      c.speed = (mag > longint'(pmd_pkg::SPEED_CAP)) ? pmd_pkg::SPEED_CAP : mag[6:0];
    end
    cmd_q.push_back(c);
  endtask

  always @(posedge clk) begin : watch
    drive_cmd_t got;
    drive_cmd_t want;
    if (rst) begin
      loop_on    = 1'b0;
      kp         = '0;
      ki         = '0;
      kd         = '0;
      last_err   = '0;
      integ      = '0;
      fail_count = 0;
      cmd_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[31:0], m_tdata[38:32], m_tdata[39], m_tuser};
        if (cmd_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected word, expected none, actual cv=%0d spd=%0d rev=%0b zs=%0b",
                   $time, $signed(got.control), got.speed, got.reverse, got.zero_step);
        end else begin
          want = cmd_q.pop_front();
          if (got !== want) begin
            fail_count++;
            $display("%0t: mismatch, expected cv=%0d spd=%0d rev=%0b zs=%0b", $time,
                     $signed(want.control), want.speed, want.reverse, want.zero_step);
            $display("%0t:           actual   cv=%0d spd=%0d rev=%0b zs=%0b", $time,
                     $signed(got.control), got.speed, got.reverse, got.zero_step);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        predict_cmd(s_tdata);
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[pmd_pkg::ADDR_W-1:2])
          pmd_pkg::REG_ENABLE: loop_on = pwdata[0];
          pmd_pkg::REG_KP:     kp = pwdata[15:0];
          pmd_pkg::REG_KI:     ki = pwdata[15:0];
          pmd_pkg::REG_KD:     kd = pwdata[15:0];
          default: ;
        endcase
      end
    end
    pending = cmd_q.size();
  end

endmodule

>>> bench/pid_motor_drive_test.sv
// Testbench top for the PID motor drive: clock, reset, stimulus, sink and verdict.
`timescale 1ns / 1ps

module pid_motor_drive_test;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  // measured_angle[15:0], time_step[31:16], target_angle[47:32]
  logic [47:0]                s_tdata = '0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  // control_value[31:0], motor_speed[38:32], motor_reverse[39]
  logic [39:0]                m_tdata;
  // zero_step_flag[0]
  logic                       m_tuser;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [pmd_pkg::ADDR_W-1:0] paddr = '0;
  logic [pmd_pkg::DATA_W-1:0] pwdata = '0;
  logic [pmd_pkg::DATA_W-1:0] prdata;
  logic                       pready;
  logic                       quiet = 1'b0;
  int                         fail_count;
  int                         pending;

  always #6 clk = ~clk;

  pid_motor_drive i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  pid_motor_drive_check i_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .pending(pending)
  );

  function automatic logic [15:0] pick_angle();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: v = $urandom_range(0, 511) - 256;
      1: v = 32'h7FFF;
      2: v = 32'h8000;
      default: v = $urandom;
    endcase
    return v[15:0];
  endfunction

  function automatic logic [15:0] pick_step();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = $urandom_range(1, 4);
      2: v = 32'hFFFF;
      default: v = $urandom;
    endcase
    return v[15:0];
  endfunction

  function automatic logic [15:0] pick_gain();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = 32'hFFFF;
      2, 3: v = $urandom_range(0, 511);
      default: v = $urandom;
    endcase
    return v[15:0];
  endfunction

  task automatic send_word(input logic [15:0] meas, input logic [15:0] step,
                           input logic [15:0] target);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {target, step, meas};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_loop(input logic en, input logic [15:0] p, input logic [15:0] i,
                          input logic [15:0] d);
    reg_write(pmd_pkg::REG_ENABLE, {31'b0, en});
    reg_write(pmd_pkg::REG_KP, {16'b0, p});
    reg_write(pmd_pkg::REG_KI, {16'b0, i});
    reg_write(pmd_pkg::REG_KD, {16'b0, d});
  endtask

  // stop offering and wait until every expected word is back
  task automatic settle();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic run_phase(input int count);
    logic en;
    en = ($urandom_range(0, 7) != 0);
    set_loop(en, pick_gain(), pick_gain(), pick_gain());
    repeat (count) send_word(pick_angle(), pick_step(), pick_angle());
    settle();
  endtask

  // sink: short random gaps, plus long hold-offs so the block backs up
  initial begin : sink
    int hold_left;
    int gap_left;
    int seen;
    int next_hold;
    hold_left = 0;
    gap_left  = 0;
    seen      = 0;
    next_hold = 300;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) seen++;
      if (seen >= next_hold && !quiet) begin
        hold_left = 500;
        next_hold += 700;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (gap_left > 0) begin
        m_tready <= 1'b0;
        gap_left--;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        gap_left = $urandom_range(0, 3);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // disabled out of reset
    send_word(16'h1234, 16'h0100, 16'h4321);
    send_word(16'h8000, 16'h0000, 16'h7FFF);
    settle();

    // small negative output still reverses
    set_loop(1'b1, 16'h0001, 16'h0000, 16'h0000);
    send_word(16'h0001, 16'h0000, 16'h0000);
    send_word(16'h0000, 16'h0000, 16'h0001);
    settle();

    set_loop(1'b1, 16'h0100, 16'h0100, 16'h0100);
    send_word(16'h0000, 16'h0100, 16'h0000);
    send_word(16'h7FFF, 16'hFFFF, 16'h8000);
    send_word(16'h0000, 16'h0001, 16'h7FFF);
    send_word(16'h8000, 16'h0000, 16'h1234);
    send_word(16'hFFFF, 16'h0001, 16'h0000);
    send_word(16'h0100, 16'h8000, 16'h0200);
    settle();

    set_loop(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(16'h7FFF, 16'hFFFF, 16'h8000);
    send_word(16'h0000, 16'hFFFF, 16'h7FFF);
    send_word(16'h8000, 16'h0000, 16'h8000);
    send_word(16'h5555, 16'hAAAA, 16'hAAAA);
    settle();

    // disabled with live state, then re-enabled with zero gains
    set_loop(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(16'h0200, 16'h1000, 16'h0100);
    send_word(16'hF000, 16'h0000, 16'h0FFF);
    settle();
    set_loop(1'b1, 16'h0000, 16'h0000, 16'h0000);
    send_word(16'h4000, 16'h0010, 16'h0000);
    send_word(16'hC000, 16'h0000, 16'h3FFF);
    settle();

    repeat (10) run_phase(150);
    quiet = 1'b1;
    repeat (2) run_phase(150);

    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
